// ===== hdl/efi_pkg.sv =====
// Shared constants and types for the escape-time fractal iteration block.
// No dependencies; used by efi_cfg, efi_mul and the top level.
package efi_pkg;

    localparam int DATA_W      = 32;
    localparam int PROD_W      = 2 * DATA_W;
    localparam int FRAC_BITS   = 28;
    localparam int COUNT_WIDTH = 12;
    localparam int MAX_ITER_W  = 12;
    localparam int MODE_W      = 2;
    localparam int ADDR_W      = 4;
    localparam int PDATA_W     = 32;

    // escape when x*x + y*y >= 4.0 at full product scale
    localparam int ESC_SHIFT = 2 * FRAC_BITS + 2;
    localparam logic [PROD_W-1:0] ESC_BOUND =
        (ESC_SHIFT < PROD_W) ? (PROD_W'(1) << ESC_SHIFT) : '1;

    localparam logic signed [PROD_W-1:0] SAT_MAX = PROD_W'(64'sh0000_0000_7FFF_FFFF);
    localparam logic signed [PROD_W-1:0] SAT_MIN = PROD_W'(64'shFFFF_FFFF_8000_0000);

    // register indexes
    localparam logic [1:0] REG_MODE     = 2'd0;
    localparam logic [1:0] REG_JULIA_RE = 2'd1;
    localparam logic [1:0] REG_JULIA_IM = 2'd2;
    localparam logic [1:0] REG_MAX_ITER = 2'd3;

    // mode codes
    localparam logic [MODE_W-1:0] MODE_MANDEL = 2'd0;
    localparam logic [MODE_W-1:0] MODE_SHIP   = 2'd1;
    localparam logic [MODE_W-1:0] MODE_JULIA  = 2'd2;

    localparam logic [MAX_ITER_W-1:0] MAX_ITER_RESET = 12'd256;

    typedef struct packed {
        logic [MODE_W-1:0]            mode;
        logic signed [DATA_W-1:0]     julia_re;
        logic signed [DATA_W-1:0]     julia_im;
        logic [MAX_ITER_W-1:0]        max_iter;
    } t_cfg;

endpackage

// ===== hdl/efi_cfg.sv =====
// Configuration register bank behind an APB-style port.
// Depends on efi_pkg for register indexes, reset values and t_cfg.
module efi_cfg (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [efi_pkg::ADDR_W-1:0]       paddr,
    input  logic [efi_pkg::PDATA_W-1:0]      pwdata,
    output logic [efi_pkg::PDATA_W-1:0]      prdata,
    output logic                             pready,
    output efi_pkg::t_cfg                    o_cfg
);

    efi_pkg::t_cfg r_cfg;
    logic          w_wr;

    assign pready = 1'b1;
    assign w_wr   = psel && penable && pwrite;
    assign o_cfg  = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.mode     <= efi_pkg::MODE_MANDEL;
            r_cfg.julia_re <= '0;
            r_cfg.julia_im <= '0;
            r_cfg.max_iter <= efi_pkg::MAX_ITER_RESET;
        end else if (w_wr) begin
            unique case (paddr[3:2])
                efi_pkg::REG_MODE:     r_cfg.mode     <= pwdata[efi_pkg::MODE_W-1:0];
                efi_pkg::REG_JULIA_RE: r_cfg.julia_re <= pwdata[efi_pkg::DATA_W-1:0];
                efi_pkg::REG_JULIA_IM: r_cfg.julia_im <= pwdata[efi_pkg::DATA_W-1:0];
                efi_pkg::REG_MAX_ITER: r_cfg.max_iter <= pwdata[efi_pkg::MAX_ITER_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[3:2])
            efi_pkg::REG_MODE:     prdata = efi_pkg::PDATA_W'(r_cfg.mode);
            efi_pkg::REG_JULIA_RE: prdata = efi_pkg::PDATA_W'(unsigned'(r_cfg.julia_re));
            efi_pkg::REG_JULIA_IM: prdata = efi_pkg::PDATA_W'(unsigned'(r_cfg.julia_im));
            efi_pkg::REG_MAX_ITER: prdata = efi_pkg::PDATA_W'(r_cfg.max_iter);
            default:               prdata = '0;
        endcase
    end

endmodule

// ===== hdl/efi_mul.sv =====
// Shared signed 32x32 multiplier with a registered 64-bit product.
// Depends on efi_pkg for operand and product widths.
module efi_mul (
    input  logic                              i_clk,
    input  logic signed [efi_pkg::DATA_W-1:0] i_a,
    input  logic signed [efi_pkg::DATA_W-1:0] i_b,
    output logic signed [efi_pkg::PROD_W-1:0] o_p
);

    logic signed [efi_pkg::PROD_W-1:0] r_p;
    logic signed [efi_pkg::PROD_W-1:0] n_p;

    assign n_p = efi_pkg::PROD_W'(i_a) * efi_pkg::PROD_W'(i_b);
    assign o_p = r_p;

    always_ff @(posedge i_clk) begin
        r_p <= n_p;
    end

endmodule

// ===== hdl/escape_time_fractal_iteration.sv =====
// Escape-time fractal iteration (Mandelbrot, burning ship, Julia), top level.
// Depends on efi_pkg, efi_cfg and efi_mul.
//
// Takes one Q4.28 point per input word and returns its escape-time count.
// One signed 32x32 multiplier is shared by the three products of every
// iteration (x*x, y*y, x*y), and a fourth state forms the saturated update,
// so an iteration steps through S_XX, S_YY, S_XY and S_UPD. A point holds
// the input side busy until it stops on the limit or escapes, plus any
// wait for the output register to free up.
// The result sits in an output register, so the next point is accepted
// while the previous count waits to be taken.
module escape_time_fractal_iteration #(
    parameter int COUNT_WIDTH = efi_pkg::COUNT_WIDTH
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // config port
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [efi_pkg::ADDR_W-1:0]        paddr,
    input  logic [efi_pkg::PDATA_W-1:0]       pwdata,
    output logic [efi_pkg::PDATA_W-1:0]       prdata,
    output logic                              pready,
    // input stream
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    input  logic [2*efi_pkg::DATA_W-1:0]      s_axis_tdata,   // [31:0] c_re, [63:32] c_im
    // output stream
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    output logic [((COUNT_WIDTH+7)/8)*8-1:0]  m_axis_tdata    // [COUNT_WIDTH-1:0] iterations
);

    localparam int OUT_W = ((COUNT_WIDTH + 7) / 8) * 8;
    localparam int LIM_W = (COUNT_WIDTH > efi_pkg::MAX_ITER_W) ? COUNT_WIDTH
                                                                : efi_pkg::MAX_ITER_W;
    localparam int DW = efi_pkg::DATA_W;
    localparam int PW = efi_pkg::PROD_W;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_XX   = 3'd1;
    localparam logic [2:0] S_YY   = 3'd2;
    localparam logic [2:0] S_XY   = 3'd3;
    localparam logic [2:0] S_UPD  = 3'd4;
    localparam logic [2:0] S_DONE = 3'd5;

    efi_pkg::t_cfg w_cfg;

    logic [2:0]             r_state, n_state;
    logic signed [DW-1:0]   r_x, r_y, r_ar, r_ai;
    logic                   r_ship;
    logic [COUNT_WIDTH-1:0] r_limit;
    logic [COUNT_WIDTH-1:0] r_n;
    logic signed [PW-1:0]   r_xx, r_yy;
    logic                   r_out_valid;
    logic [COUNT_WIDTH-1:0] r_out_count;

    logic signed [DW-1:0]   w_mul_a, w_mul_b;
    logic signed [PW-1:0]   w_prod;
    logic                   w_accept;
    logic                   w_out_free;
    logic [LIM_W-1:0]       w_max_ext, w_cnt_max;
    logic [PW-1:0]          w_mag;
    logic                   w_escape;
    logic signed [PW-1:0]   w_re, w_im, w_im_abs, w_re_sum, w_im_sum;
    logic signed [DW-1:0]   w_x_next, w_y_next;

    function automatic logic signed [DW-1:0] sat32(input logic signed [PW-1:0] v);
        if (v > efi_pkg::SAT_MAX) begin
            return efi_pkg::SAT_MAX[DW-1:0];
        end else if (v < efi_pkg::SAT_MIN) begin
            return efi_pkg::SAT_MIN[DW-1:0];
        end
        return v[DW-1:0];
    endfunction

    efi_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    efi_mul u_mul (
        .i_clk (i_clk),
        .i_a   (w_mul_a),
        .i_b   (w_mul_b),
        .o_p   (w_prod)
    );

    // hold off input words while reset is applied
    assign s_axis_tready = (r_state == S_IDLE) && i_rst_n;
    assign w_accept      = s_axis_tvalid && s_axis_tready;
    assign w_out_free    = !r_out_valid || m_axis_tready;
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = OUT_W'(r_out_count);

    // clamp the limit to what the counter can hold
    assign w_max_ext = LIM_W'(w_cfg.max_iter);
    assign w_cnt_max = LIM_W'({COUNT_WIDTH{1'b1}});

    // operand select for the shared multiplier
    always_comb begin
        case (r_state)
            S_XX:    begin w_mul_a = r_x; w_mul_b = r_x; end
            S_YY:    begin w_mul_a = r_y; w_mul_b = r_y; end
            default: begin w_mul_a = r_x; w_mul_b = r_y; end
        endcase
    end

    // in S_XY the product register holds y*y while r_xx holds x*x
    assign w_mag    = unsigned'(r_xx) + unsigned'(w_prod);
    assign w_escape = (w_mag >= efi_pkg::ESC_BOUND);

    // in S_UPD the product register holds x*y
    assign w_re     = (r_xx - r_yy) >>> efi_pkg::FRAC_BITS;
    assign w_im     = w_prod >>> (efi_pkg::FRAC_BITS - 1);
    assign w_im_abs = (r_ship && w_im[PW-1]) ? -w_im : w_im;
    assign w_re_sum = w_re + PW'(r_ar);
    assign w_im_sum = w_im_abs + PW'(r_ai);
    assign w_x_next = sat32(w_re_sum);
    assign w_y_next = sat32(w_im_sum);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: if (w_accept) n_state = S_XX;
            S_XX:   n_state = (r_n >= r_limit) ? S_DONE : S_YY;
            S_YY:   n_state = S_XY;
            S_XY:   n_state = w_escape ? S_DONE : S_UPD;
            S_UPD:  n_state = S_XX;
            S_DONE: if (w_out_free) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_n         <= '0;
        end else begin
            r_state <= n_state;
            if (r_state == S_DONE && w_out_free) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
            if (w_accept) begin
                r_n <= '0;
            end else if (r_state == S_UPD) begin
                r_n <= r_n + COUNT_WIDTH'(1);
            end
        end
    end

    // payload: point, addend and working values
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_x     <= s_axis_tdata[DW-1:0];
            r_y     <= s_axis_tdata[2*DW-1:DW];
            r_ar    <= (w_cfg.mode == efi_pkg::MODE_JULIA) ? w_cfg.julia_re
                                                           : s_axis_tdata[DW-1:0];
            r_ai    <= (w_cfg.mode == efi_pkg::MODE_JULIA) ? w_cfg.julia_im
                                                           : s_axis_tdata[2*DW-1:DW];
            r_ship  <= (w_cfg.mode == efi_pkg::MODE_SHIP);
            r_limit <= (w_max_ext > w_cnt_max) ? w_cnt_max[COUNT_WIDTH-1:0]
                                               : w_max_ext[COUNT_WIDTH-1:0];
        end else if (r_state == S_UPD) begin
            r_x <= w_x_next;
            r_y <= w_y_next;
        end
        if (r_state == S_YY) begin
            r_xx <= w_prod;
        end
        if (r_state == S_XY) begin
            r_yy <= w_prod;
        end
        if (r_state == S_DONE && w_out_free) begin
            r_out_count <= r_n;
        end
    end

    // count never runs past the captured limit while a point is in flight
    a_count_in_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE) |-> (r_n <= r_limit))
        else $error("iteration count passed the limit");

    a_accept_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> (r_state == S_XX && r_n == '0))
        else $error("accepted word did not start an iteration");

    a_done_loads_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DONE && w_out_free) |=> (r_out_valid && r_state == S_IDLE))
        else $error("finished count not placed in output register");

    a_update_follows_xy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_UPD) |-> ($past(r_state) == S_XY && !$past(w_escape)))
        else $error("update entered without an escape test");

endmodule

// ===== dv/tb_escape_time_fractal_iteration.sv =====
// Self-checking testbench for escape_time_fractal_iteration: streams Q4.28 points in, predicts each
// escape count in place and compares every returned word. Depends on efi_pkg and the block's RTL.
module tb_escape_time_fractal_iteration;

    localparam int COUNT_W = efi_pkg::COUNT_WIDTH;
    localparam int OUT_W = ((COUNT_W + 7) / 8) * 8;
    localparam int FRAC = efi_pkg::FRAC_BITS;
    localparam int COUNT_MAX = (1 << COUNT_W) - 1;
    localparam logic [63:0] ESCAPE_BOUND = 64'd1 << (2 * FRAC + 2);
    localparam int TIMEOUT_CYCLES = 5_000_000;
    localparam int LONG_HOLD_CYCLES = 500;
    localparam int ITEM_TARGET = 600;

    // handy Q4.28 values
    localparam logic [31:0] Q_ZERO = 32'h0000_0000;
    localparam logic [31:0] Q_MIN = 32'h8000_0000;
    localparam logic [31:0] Q_MAX = 32'h7FFF_FFFF;
    localparam logic [31:0] Q_ONE = 32'h1000_0000;
    localparam logic [31:0] Q_NEG_ONE = 32'hF000_0000;
    localparam logic [31:0] Q_NEG_TWO = 32'hE000_0000;

    typedef struct {
        logic [31:0] re;
        logic [31:0] im;
        bit          drain;
    } t_point;

    logic                        i_clk = 1'b0;
    logic                        i_rst_n = 1'b0;
    logic                        psel = 1'b0;
    logic                        penable = 1'b0;
    logic                        pwrite = 1'b0;
    logic [efi_pkg::ADDR_W-1:0]  paddr = '0;
    logic [efi_pkg::PDATA_W-1:0] pwdata = '0;
    logic [efi_pkg::PDATA_W-1:0] prdata;
    logic                        pready;
    logic                        s_axis_tvalid = 1'b0;
    logic                        s_axis_tready;
    logic [63:0]                 s_axis_tdata = '0;   // [31:0] c_re, [63:32] c_im
    logic                        m_axis_tvalid;
    logic                        m_axis_tready = 1'b0;
    logic [OUT_W-1:0]            m_axis_tdata;        // [COUNT_W-1:0] iterations

    // shadow of the block's registers
    logic [efi_pkg::MODE_W-1:0]     cfg_mode = efi_pkg::MODE_MANDEL;
    logic signed [31:0]             cfg_julia_re = '0;
    logic signed [31:0]             cfg_julia_im = '0;
    logic [efi_pkg::MAX_ITER_W-1:0] cfg_limit = efi_pkg::MAX_ITER_RESET;

    t_point              point_q[$];
    logic [COUNT_W-1:0]  count_q[$];
    int                  n_in = 0;
    int                  n_out = 0;
    int                  n_queued = 0;
    int                  n_errors = 0;
    int                  hold_left = 0;
    bit                  hold_taken = 1'b0;
    logic                long_hold_req = 1'b0;

    escape_time_fractal_iteration uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always #6 i_clk = ~i_clk;

    function automatic longint clamp_q(input longint v);
        if (v > 64'sd2147483647) return 64'sd2147483647;
        if (v < -64'sd2147483648) return -64'sd2147483648;
        return v;
    endfunction

    function automatic logic [COUNT_W-1:0] escape_count(input logic signed [31:0] c_re,
                                                         input logic signed [31:0] c_im);
        longint x, y, add_re, add_im, xx, yy, re, im;
        int     lim, n;
        bit     escaped;
        x = c_re;
        y = c_im;
        add_re = (cfg_mode == efi_pkg::MODE_JULIA) ? longint'(cfg_julia_re) : x;
        add_im = (cfg_mode == efi_pkg::MODE_JULIA) ? longint'(cfg_julia_im) : y;
        lim = cfg_limit;
        if (lim > COUNT_MAX) lim = COUNT_MAX;
        n = 0;
        escaped = 1'b0;
        while (n < lim && !escaped) begin
            xx = x * x;
            yy = y * y;
            if ($unsigned(xx) + $unsigned(yy) >= ESCAPE_BOUND) begin
                escaped = 1'b1;
            end else begin
                // arithmetic shift floors toward minus infinity
                re = (xx - yy) >>> FRAC;
                im = (x * y) >>> (FRAC - 1);
                if (cfg_mode == efi_pkg::MODE_SHIP && im < 0) im = -im;
                x = clamp_q(re + add_re);
                y = clamp_q(im + add_im);
                n++;
            end
        end
        return n[COUNT_W-1:0];
    endfunction

    function automatic int tx_idle_pct();
        if (n_in < ITEM_TARGET / 3) return 35;
        if (n_in < 2 * ITEM_TARGET / 3) return 69;
        return 0;
    endfunction

    function automatic int rx_idle_pct();
        if (n_out < ITEM_TARGET / 3) return 69;
        if (n_out < 2 * ITEM_TARGET / 3) return 35;
        return 0;
    endfunction

    task automatic flag_error(input string msg);
        $display("ERROR at %0t: %s", $time, msg);
        n_errors++;
    endtask

    // driver: feed points from the queue, predict each accepted word
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata <= '0;
        end else begin
            if (s_axis_tvalid && s_axis_tready) begin
                count_q.push_back(escape_count(s_axis_tdata[31:0], s_axis_tdata[63:32]));
                n_in++;
            end
            if (!s_axis_tvalid || s_axis_tready) begin
                // hold at a drain marker until every count is back
                if (point_q.size() != 0 && point_q[0].drain && count_q.size() == 0)
                    void'(point_q.pop_front());
                if (point_q.size() != 0 && !point_q[0].drain &&
                    $urandom_range(99) >= tx_idle_pct()) begin
                    s_axis_tdata <= {point_q[0].im, point_q[0].re};
                    s_axis_tvalid <= 1'b1;
                    void'(point_q.pop_front());
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // monitor: take counts and compare with the oldest prediction
    always @(posedge i_clk) begin
        logic [COUNT_W-1:0] want;
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                n_out++;
                if (count_q.size() == 0) begin
                    flag_error($sformatf("count %0d with no point outstanding",
                                         m_axis_tdata[COUNT_W-1:0]));
                end else begin
                    want = count_q.pop_front();
                    if (m_axis_tdata[COUNT_W-1:0] !== want)
                        flag_error($sformatf("iterations %0d, predicted %0d",
                                             m_axis_tdata[COUNT_W-1:0], want));
                end
            end
            if (hold_left > 0) begin
                hold_left <= hold_left - 1;
                m_axis_tready <= 1'b0;
            end else if (long_hold_req && !hold_taken) begin
                hold_left <= LONG_HOLD_CYCLES;
                hold_taken <= 1'b1;
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= ($urandom_range(99) >= rx_idle_pct());
            end
        end
    end

    task automatic push_point(input logic [31:0] re, input logic [31:0] im);
        t_point p;
        p.re = re;
        p.im = im;
        p.drain = 1'b0;
        point_q.push_back(p);
        n_queued++;
    endtask

    task automatic push_drain();
        t_point p;
        p.re = '0;
        p.im = '0;
        p.drain = 1'b1;
        point_q.push_back(p);
    endtask

    task automatic wait_idle();
        do @(negedge i_clk);
        while (point_q.size() != 0 || s_axis_tvalid || count_q.size() != 0);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic cfg_write(input logic [1:0] idx, input logic [31:0] value);
        @(posedge i_clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk);
        while (!pready);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        case (idx)
            efi_pkg::REG_MODE:     cfg_mode = value[efi_pkg::MODE_W-1:0];
            efi_pkg::REG_JULIA_RE: cfg_julia_re = value;
            efi_pkg::REG_JULIA_IM: cfg_julia_im = value;
            efi_pkg::REG_MAX_ITER: cfg_limit = value[efi_pkg::MAX_ITER_W-1:0];
            default: ;
        endcase
    endtask

    task automatic set_config(input logic [1:0] mode, input logic [31:0] jre,
                              input logic [31:0] jim, input logic [11:0] limit);
        wait_idle();
        cfg_write(efi_pkg::REG_MODE, 32'(mode));
        cfg_write(efi_pkg::REG_JULIA_RE, jre);
        cfg_write(efi_pkg::REG_JULIA_IM, jim);
        cfg_write(efi_pkg::REG_MAX_ITER, 32'(limit));
    endtask

    // mostly within +-2.0 on each axis, some anywhere, some at the rails
    function automatic logic [31:0] random_coord();
        int unsigned pick;
        pick = $urandom_range(99);
        if (pick < 75) return $urandom_range(32'h3FFF_FFFF) - 32'h2000_0000;
        if (pick < 92) return $urandom;
        if (pick < 96) return Q_MIN;
        return Q_MAX;
    endfunction

    function automatic logic [31:0] random_julia();
        if ($urandom_range(99) < 80) return $urandom_range(32'h1FFF_FFFF) - 32'h1000_0000;
        return $urandom;
    endfunction

    initial begin
        int unsigned r;
        int          lim;
        int          batch;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reset settings: Mandelbrot, limit 256
        push_point(Q_ZERO, Q_ZERO);
        push_point(Q_MIN, Q_MIN);
        push_point(Q_MAX, Q_MAX);
        push_point(Q_MIN, Q_MAX);
        push_point(Q_MAX, Q_MIN);
        push_point(Q_NEG_TWO, Q_ZERO);
        push_point(Q_NEG_ONE, Q_ZERO);
        push_point(32'h0400_0000, Q_ZERO);
        push_point(32'hF400_0000, 32'h019A_999A);
        push_point(Q_ZERO, Q_ONE);
        push_point(32'h0000_0001, 32'hFFFF_FFFF);
        push_drain();
        push_point(32'h1FFF_FFFF, Q_ZERO);

        // unused mode code with a zero limit, then with a small one
        set_config(2'd3, Q_MAX, Q_MIN, 12'd0);
        push_point(Q_ZERO, Q_ZERO);
        push_point(Q_MAX, Q_MIN);
        set_config(2'd3, Q_ZERO, Q_ZERO, 12'd20);
        push_point(32'hFE00_0000, 32'h0A00_0000);
        push_point(Q_NEG_ONE, Q_ZERO);

        set_config(efi_pkg::MODE_SHIP, Q_ZERO, Q_ZERO, 12'd64);
        push_point(32'hE400_0000, 32'hFF85_1EB8);
        push_point(32'h04CC_CCCD, 32'hF800_0000);
        push_point(32'hF800_0000, 32'h0800_0000);

        set_config(efi_pkg::MODE_JULIA, 32'hF333_3333, 32'h027F_BE77, 12'd100);
        push_point(Q_ZERO, Q_ZERO);
        push_point(32'h0400_0000, 32'hFC00_0000);
        push_point(Q_MIN, Q_MAX);

        // saturating constant
        set_config(efi_pkg::MODE_JULIA, Q_MIN, Q_MAX, 12'd1);
        push_point(Q_ZERO, Q_ZERO);
        set_config(efi_pkg::MODE_JULIA, Q_MAX, Q_MIN, 12'd5);
        push_point(Q_ZERO, Q_ZERO);

        // full-range limit on points that never escape
        set_config(efi_pkg::MODE_MANDEL, Q_ZERO, Q_ZERO, 12'd4095);
        push_point(Q_ZERO, Q_ZERO);
        push_point(Q_NEG_ONE, Q_ZERO);

        // short counts while the receiver stalls for a long stretch
        set_config(efi_pkg::MODE_MANDEL, Q_ZERO, Q_ZERO, 12'd8);
        repeat (60) push_point(random_coord(), random_coord());
        long_hold_req <= 1'b1;

        while (n_queued < ITEM_TARGET) begin
            r = $urandom_range(99);
            if (r < 55) lim = $urandom_range(24, 1);
            else if (r < 88) lim = $urandom_range(300, 25);
            else if (r < 94) lim = $urandom_range(1);
            else lim = $urandom_range(4095, 301);
            batch = (lim > 300) ? 3 : $urandom_range(60, 20);
            set_config(2'($urandom_range(3)), random_julia(), random_julia(), 12'(lim));
            repeat (batch) begin
                push_point(random_coord(), random_coord());
                if ($urandom_range(99) < 2) push_drain();
            end
        end

        wait_idle();
        repeat (16) @(posedge i_clk);
        if (n_errors == 0) begin
            $display("tb_escape_time_fractal_iteration: clean");
        end else begin
            $display("tb_escape_time_fractal_iteration: errors");
        end
        $finish;
    end

    initial begin
        #(TIMEOUT_CYCLES * 12);
        $display("tb_escape_time_fractal_iteration: errors");
        $finish;
    end

endmodule
